### rtl/uewc_pkg.sv
// Shared types, pattern constants and match functions of the URL / e-mail word classifier.
// No dependencies.
package uewc_pkg;

  // Six-byte window, one byte per lane.
  typedef logic [5:0][7:0] win_t;

  // One result beat.
  typedef struct packed {
    logic       url_like;
    logic       email_like;
    logic [7:0] dot_count;
  } res_t;

  // Match pattern: text and its length in bytes.
  // Head patterns: first char in byte 5, padded with zeros below.
  // Tail patterns: last char in byte 0, padded with zeros above.
  typedef struct packed {
    win_t       text;
    logic [2:0] len;
  } pat_t;

  localparam int NumHeads     = 5;
  localparam int NumTails     = 14;
  localparam int NumMailTails = 6;

  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharSlash = 8'h2f;

  localparam logic [2:0] LenMax  = 3'd7;
  localparam logic [2:0] WinLen  = 3'd6;
  localparam logic [7:0] DotsMax = 8'hff;

  localparam pat_t HEADS [NumHeads] = '{
    '{text: {"http:",  8'h00}, len: 3'd5},
    '{text: {"ftp:",  16'h00}, len: 3'd4},
    '{text: "https:",          len: 3'd6},
    '{text: {"mms:",  16'h00}, len: 3'd4},
    '{text: {"www.",  16'h00}, len: 3'd4}
  };

  // The first NumMailTails entries are also the e-mail domain suffixes.
  localparam pat_t TAILS [NumTails] = '{
    '{text: {16'h00, ".com"},  len: 3'd4},
    '{text: {16'h00, ".edu"},  len: 3'd4},
    '{text: {16'h00, ".gov"},  len: 3'd4},
    '{text: {16'h00, ".net"},  len: 3'd4},
    '{text: {16'h00, ".org"},  len: 3'd4},
    '{text: {24'h00, ".cn"},   len: 3'd3},
    '{text: {16'h00, ".htm"},  len: 3'd4},
    '{text: {16'h00, ".asp"},  len: 3'd4},
    '{text: {16'h00, ".jsp"},  len: 3'd4},
    '{text: {16'h00, ".php"},  len: 3'd4},
    '{text: {16'h00, ".mht"},  len: 3'd4},
    '{text: {8'h00,  ".html"}, len: 3'd5},
    '{text: {8'h00,  ".aspx"}, len: 3'd5},
    '{text: ".shtml",          len: 3'd6}
  };

  // Prefix window: byte i holds the i-th byte of the word.
  function automatic logic head_hit(win_t pre, logic [2:0] len, pat_t p);
    logic ok;
    ok = (len > p.len);
    for (int i = 0; i < 6; i++) begin
      if ((3'(i) < p.len) && (pre[i] != p.text[5 - i])) ok = 1'b0;
    end
    return ok;
  endfunction

  // Tail window: byte j holds the j-th byte counted back from the end.
  function automatic logic tail_hit(win_t tw, logic [2:0] len, pat_t p);
    logic ok;
    ok = (len > p.len);
    for (int j = 0; j < 6; j++) begin
      if ((3'(j) < p.len) && (tw[j] != p.text[j])) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### rtl/uewc_if.sv
// Stream interfaces for the classifier: byte channel in, result channel out.
// Depends on nothing.
interface uewc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface uewc_out_if;
  logic       valid;
  logic       ready;
  logic       url_like;
  logic       email_like;
  logic [7:0] dot_count;

  modport source (output valid, output url_like, output email_like, output dot_count,
                  input ready);
  modport sink   (input valid, input url_like, input email_like, input dot_count,
                  output ready);
endinterface

### rtl/url_email_word_classifier.sv
// Top level of the URL / e-mail word classifier: front end plus result queue.
// Depends on uewc_pkg, uewc_if, uewc_front and uewc_queue.
//
// Usage:
//   in_s carries one byte of a word per beat (char_byte) with last_byte set on the
//   final byte. out_s carries one result beat per word: url_like, email_like and
//   dot_count (dots after the first byte, saturating at 255).
//   Throughput: one byte per cycle, sustained while the result queue has room, including across word boundaries.
//   The result of a word is written into the queue when its last byte is accepted
//   and is driven on out_s once the results ahead of it have been taken.
//   The front end updates its prefix and tail windows and compares all patterns
//   in the cycle a byte is accepted; the result goes into a QueueDepth-entry queue.
//   Stall: while the receiver holds ready low, results pile up in the queue; once
//   it is full, in_s.ready drops and bytes wait. Bytes keep flowing as long as
//   there is room for one more result.
//   Reset (rst_n low, synchronous) clears the word state and empties the queue;
//   the block is ready in the first cycle after reset.
module url_email_word_classifier
  import uewc_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  uewc_in_if.sink    in_s,
  uewc_out_if.source out_s
);

  logic q_full;
  logic push;
  res_t push_res;

  uewc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .q_full   (q_full),
    .push     (push),
    .push_res (push_res)
  );

  uewc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .full     (q_full),
    .out_s    (out_s)
  );

endmodule

### rtl/uewc_front.sv
// Front end: takes word bytes, tracks prefix/tail windows and counters, classifies on last byte.
// Depends on uewc_pkg and uewc_in_if.
module uewc_front
  import uewc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  uewc_in_if.sink    in_s,
  input  logic       q_full,
  output logic       push,
  output res_t       push_res
);

  win_t       pre_r,   pre_nxt;
  win_t       raw_r,   raw_nxt;
  win_t       strip_r, strip_nxt;
  logic [2:0] raw_len_r,   raw_len_nxt;
  logic [2:0] strip_len_r, strip_len_nxt;
  logic [2:0] slash_r,     slash_nxt;
  logic       at_r,        at_nxt;
  logic [7:0] dots_r,      dots_nxt;

  logic       accept;
  logic [7:0] b;
  logic [2:0] pend;
  logic [4:0] strip_sum;
  logic       url_hit;
  logic       mail_hit;

  assign in_s.ready = !q_full;
  assign accept     = in_s.valid && in_s.ready;
  assign b          = in_s.char_byte;

  // Word state after this byte
  always_comb begin
    pre_nxt       = pre_r;
    raw_nxt       = {raw_r[4:0], b};
    strip_nxt     = strip_r;
    strip_len_nxt = strip_len_r;
    slash_nxt     = slash_r;
    at_nxt        = at_r;
    dots_nxt      = dots_r;
    pend          = (slash_r > WinLen) ? WinLen : slash_r;
    strip_sum     = 5'(strip_len_r) + 5'(slash_r) + 5'd1;

    if (raw_len_r != 3'd0) begin
      if (b == CharAt) at_nxt = 1'b1;
      if ((b == CharDot) && (dots_r != DotsMax)) dots_nxt = dots_r + 8'd1;
    end
    if (raw_len_r < WinLen) pre_nxt[raw_len_r] = b;
    raw_len_nxt = (raw_len_r == LenMax) ? LenMax : raw_len_r + 3'd1;

    if (b == CharSlash) begin
      slash_nxt = (slash_r == LenMax) ? LenMax : slash_r + 3'd1;
    end else begin
      // flush pending slashes, then the byte itself
      strip_nxt[0] = b;
      for (int k = 1; k < 6; k++) begin
        if (3'(k) <= pend) strip_nxt[k] = CharSlash;
        else               strip_nxt[k] = strip_r[3'(k - 1) - pend];
      end
      strip_len_nxt = (strip_sum > 5'(LenMax)) ? LenMax : strip_sum[2:0];
      slash_nxt     = 3'd0;
    end
  end

  // Classify against the updated windows
  always_comb begin
    url_hit  = 1'b0;
    mail_hit = 1'b0;
    for (int i = 0; i < NumHeads; i++) begin
      if (head_hit(pre_nxt, strip_len_nxt, HEADS[i])) url_hit = 1'b1;
    end
    for (int i = 0; i < NumTails; i++) begin
      if (tail_hit(strip_nxt, strip_len_nxt, TAILS[i])) url_hit = 1'b1;
    end
    for (int i = 0; i < NumMailTails; i++) begin
      if (tail_hit(raw_nxt, raw_len_nxt, TAILS[i])) mail_hit = 1'b1;
    end
  end

  assign push                = accept && in_s.last_byte;
  assign push_res.url_like   = url_hit && !at_nxt;
  assign push_res.email_like = mail_hit && at_nxt;
  assign push_res.dot_count  = dots_nxt;

  // Advance word state; clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pre_r       <= '0;
      raw_r       <= '0;
      strip_r     <= '0;
      raw_len_r   <= '0;
      strip_len_r <= '0;
      slash_r     <= '0;
      at_r        <= 1'b0;
      dots_r      <= '0;
    end else if (accept) begin
      pre_r       <= pre_nxt;
      raw_r       <= raw_nxt;
      strip_r     <= strip_nxt;
      raw_len_r   <= raw_len_nxt;
      strip_len_r <= strip_len_nxt;
      slash_r     <= slash_nxt;
      at_r        <= at_nxt;
      dots_r      <= dots_nxt;
    end
  end

endmodule

### rtl/uewc_queue.sv
// Result queue between front end and output channel; head drives the result beat.
// Depends on uewc_pkg and uewc_out_if.
module uewc_queue
  import uewc_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       push_res,
  output logic       full,
  uewc_out_if.source out_s
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  res_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r,    cnt_nxt;
  logic            pop;
  res_t            head;

  assign full  = (cnt_r == CntW'(Depth));
  assign pop   = out_s.valid && out_s.ready;
  assign head  = mem_r[rd_ptr_r];

  assign out_s.valid      = (cnt_r != '0);
  assign out_s.url_like   = head.url_like;
  assign out_s.email_like = head.email_like;
  assign out_s.dot_count  = head.dot_count;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop)      cnt_nxt = cnt_r + CntW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the result beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule
